// File: design/ctf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctf_pkg: shared types and constants of the column trace follower
// widths of the pixel and point fields, register indexes, reset values
// ----------------------------------------------------------------------------
package ctf_pkg;

   localparam int ROW_W       = 10;
   localparam int COL_W       = 12;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // result queue
   localparam int OUT_DEPTH = 3;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PANEL_IS_LOWER = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_JUMP       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASELINE_LIMIT = 2'd2;

   localparam logic [ROW_W-1:0] MAX_JUMP_RESET       = 10'd80;
   localparam logic [ROW_W-1:0] BASELINE_LIMIT_RESET = 10'd716;

   // one trace point, point_x in the low bits
   typedef struct packed {
      logic [ROW_W-1:0] point_y;
      logic [COL_W-1:0] point_x;
   } result_type;

endpackage
`default_nettype wire

// File: design/ctf_row_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctf_row_store: set-row store of the current column
// one write port, two registered read ports, write data forwarded on a hit
// ----------------------------------------------------------------------------
module ctf_row_store #(
   parameter int DEPTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  wire logic [ctf_pkg::ROW_W-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]          rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0]          rd_addr_b,
   output logic      [ctf_pkg::ROW_W-1:0]         rd_data_a,
   output logic      [ctf_pkg::ROW_W-1:0]         rd_data_b
);

   logic [ctf_pkg::ROW_W-1:0] mem [DEPTH];
   logic [ctf_pkg::ROW_W-1:0] rd_a_ff;
   logic [ctf_pkg::ROW_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-during-write returns the new data
   always_ff @(posedge clock) begin
      rd_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
      rd_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// File: design/ctf_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctf_out_fifo: small result queue in front of the result channel
// three entries, registered head, occupancy reported for flow control
// ----------------------------------------------------------------------------
module ctf_out_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire ctf_pkg::result_type           push_data,
   input  wire logic                          pop,
   output logic                               head_valid,
   output ctf_pkg::result_type                head_data,
   output logic [ctf_pkg::OUT_CNT_W-1:0]      count
);

   ctf_pkg::result_type               entry_ff [ctf_pkg::OUT_DEPTH];
   logic [ctf_pkg::OUT_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ctf_pkg::OUT_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ctf_pkg::OUT_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                              do_pop;

   function automatic logic [ctf_pkg::OUT_PTR_W-1:0] next_ptr(
      input logic [ctf_pkg::OUT_PTR_W-1:0] p
   );
      if (p == ctf_pkg::OUT_PTR_W'(ctf_pkg::OUT_DEPTH - 1)) begin
         return '0;
      end
      return p + ctf_pkg::OUT_PTR_W'(1);
   endfunction

   always_comb begin
      do_pop    = pop && (cnt_ff != '0);
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + ctf_pkg::OUT_CNT_W'(push) - ctf_pkg::OUT_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (cnt_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = cnt_ff;

endmodule
`default_nettype wire

// File: design/column_trace_follower_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_trace_follower_unit: follows a curve through a binary mask
// picks one row per column (median or nearest to the last pick) and emits it
// ----------------------------------------------------------------------------
// usage
//   req_ carries one mask pixel per word, column by column, rows ascending;
//   req_tlast marks the last pixel of a column, req_tuser the first pixel of
//   an image (drops tracking and any partly gathered column)
//   rsp_ carries at most one trace point per column, only on column end
//   csr_ writes panel_is_lower, max_jump, baseline_limit while idle
// throughput
//   one pixel per clock while req_tready is high; set-row store: one write
//   per cycle, two registered reads at column end, with write forwarding
// result path
//   a point is taken into a register stage at the column-end edge and from
//   there into a three-entry result queue, whose head drives rsp_tvalid
// stalls
//   req_tready drops only when queue plus stage could not hold another point,
//   so the input keeps flowing while up to two finished points wait
// reset
//   synchronous, clears tracking, column count, stage and queue, and loads
//   the register reset values; the store itself is not cleared
// ----------------------------------------------------------------------------
module column_trace_follower_unit #(
   parameter int MAX_ROWS = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // pixel words
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // pixel_on [0], row_index [10:1], column_index [22:11], zero [23]
   input  wire logic [ctf_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // end_of_column
   input  wire logic                                 req_tlast,
   // start_of_image [0]
   input  wire logic                                 req_tuser,
   // point words
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // point_x [11:0], point_y [21:12], zero [23:22]
   output logic      [ctf_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // register writes
   input  wire logic                                 csr_wr_en,
   input  wire logic [ctf_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [ctf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW    = $clog2(MAX_ROWS);
   localparam int CNT_W = $clog2(MAX_ROWS + 1);
   localparam int ROW_W = ctf_pkg::ROW_W;
   localparam int COL_W = ctf_pkg::COL_W;

   // configuration registers
   logic             panel_ff, panel_in;
   logic [ROW_W-1:0] max_jump_ff, max_jump_in;
   logic [ROW_W-1:0] baseline_ff, baseline_in;

   // tracking state
   logic             prev_valid_ff, prev_valid_in;
   logic [ROW_W-1:0] prev_row_ff, prev_row_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0] closest_ff, closest_in;
   logic [ROW_W-1:0] dist_ff, dist_in;

   // decision stage, one point in flight
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_median_ff, s1_median_in;
   logic [COL_W-1:0] s1_col_ff, s1_col_in;
   logic [ROW_W-1:0] s1_y_ff, s1_y_in;

   // input word fields
   logic             pix_on;
   logic [ROW_W-1:0] pix_row;
   logic [COL_W-1:0] pix_col;
   logic             pix_eoc;
   logic             pix_soi;
   logic             acc;

   // pixel path
   logic             clr;
   logic             pv;
   logic [ROW_W-1:0] prow_res;
   logic [ROW_W-1:0] prow;
   logic [CNT_W-1:0] cnt0, cnt1;
   logic [ROW_W-1:0] cr0, cr1;
   logic [ROW_W-1:0] cd0, cd1;
   logic             take;
   logic [ROW_W-1:0] gap;
   logic             upd_closest;
   logic [CNT_W-1:0] half;
   logic             baseline_hit;
   logic             jump_bad;

   // store ports
   logic [AW-1:0]    rd_addr_a, rd_addr_b;
   logic [ROW_W-1:0] rd_data_a, rd_data_b;
   logic [ROW_W:0]   mid_sum;
   logic [ROW_W-1:0] median_y;

   // result queue
   ctf_pkg::result_type                 s1_result;
   ctf_pkg::result_type                 head;
   logic [ctf_pkg::OUT_CNT_W-1:0]       q_count;
   logic [ctf_pkg::OUT_CNT_W:0]         in_flight;

   assign pix_on  = req_tdata[0];
   assign pix_row = req_tdata[ROW_W:1];
   assign pix_col = req_tdata[ROW_W+COL_W:ROW_W+1];
   assign pix_eoc = req_tlast;
   assign pix_soi = req_tuser;

   // room for one more point even if nothing drains
   assign in_flight  = {1'b0, q_count} + (ctf_pkg::OUT_CNT_W + 1)'(s1_valid_ff);
   assign req_tready = in_flight < (ctf_pkg::OUT_CNT_W + 1)'(ctf_pkg::OUT_DEPTH);
   assign acc        = req_tvalid && req_tready;

   // median of the gathered column; odd counts read one entry twice
   assign mid_sum  = {1'b0, rd_data_a} + {1'b0, rd_data_b} + (ROW_W + 1)'(1);
   assign median_y = mid_sum[ROW_W:1];

   // register writes
   always_comb begin
      panel_in    = panel_ff;
      max_jump_in = max_jump_ff;
      baseline_in = baseline_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            ctf_pkg::CSR_PANEL_IS_LOWER: panel_in    = csr_wdata[0];
            ctf_pkg::CSR_MAX_JUMP:       max_jump_in = csr_wdata;
            ctf_pkg::CSR_BASELINE_LIMIT: baseline_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // pixel and column-end decision
   always_comb begin
      // a median point resolves the previous row from the store reads while it sits in the decision stage
      prow_res = (s1_valid_ff && s1_median_ff) ? median_y : prev_row_ff;

      // start of image clears tracking before the pixel is taken
      clr  = acc && pix_soi;
      pv   = clr ? 1'b0 : prev_valid_ff;
      prow = clr ? '0 : prow_res;
      cnt0 = clr ? '0 : cnt_ff;
      cr0  = clr ? '0 : closest_ff;
      cd0  = clr ? '1 : dist_ff;

      take = acc && pix_on && (cnt0 != CNT_W'(MAX_ROWS));
      gap  = (pix_row >= prow) ? (pix_row - prow) : (prow - pix_row);
      upd_closest = take && pv && ((cnt0 == '0) || (gap < cd0));
      cr1  = upd_closest ? pix_row : cr0;
      cd1  = upd_closest ? gap : cd0;
      cnt1 = cnt0 + CNT_W'(take);

      half      = cnt1 >> 1;
      rd_addr_b = half[AW-1:0];
      rd_addr_a = cnt1[0] ? half[AW-1:0] : (half[AW-1:0] - AW'(1));

      baseline_hit = panel_ff && (cr1 > baseline_ff);
      jump_bad     = (cd1 > max_jump_ff) && !baseline_hit;

      prev_valid_in = pv;
      prev_row_in   = prow;
      cnt_in        = cnt1;
      closest_in    = cr1;
      dist_in       = cd1;

      s1_valid_in  = 1'b0;
      s1_median_in = 1'b0;
      s1_col_in    = pix_col;
      s1_y_in      = cr1;

      if (acc && pix_eoc) begin
         cnt_in     = '0;
         closest_in = '0;
         dist_in    = '1;
         if (cnt1 == '0) begin
            // empty column drops tracking
            prev_valid_in = 1'b0;
         end else if (!pv) begin
            // median, rows come out of the store next cycle
            prev_valid_in = 1'b1;
            s1_valid_in   = 1'b1;
            s1_median_in  = 1'b1;
         end else if (jump_bad) begin
            prev_valid_in = 1'b0;
         end else begin
            prev_valid_in = 1'b1;
            prev_row_in   = cr1;
            s1_valid_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_ff      <= 1'b0;
         max_jump_ff   <= ctf_pkg::MAX_JUMP_RESET;
         baseline_ff   <= ctf_pkg::BASELINE_LIMIT_RESET;
         prev_valid_ff <= 1'b0;
         prev_row_ff   <= '0;
         cnt_ff        <= '0;
         closest_ff    <= '0;
         dist_ff       <= '1;
         s1_valid_ff   <= 1'b0;
         s1_median_ff  <= 1'b0;
      end else begin
         panel_ff      <= panel_in;
         max_jump_ff   <= max_jump_in;
         baseline_ff   <= baseline_in;
         prev_valid_ff <= prev_valid_in;
         prev_row_ff   <= prev_row_in;
         cnt_ff        <= cnt_in;
         closest_ff    <= closest_in;
         dist_ff       <= dist_in;
         s1_valid_ff   <= s1_valid_in;
         s1_median_ff  <= s1_median_in;
      end
   end

   // point payload, no reset needed
   always_ff @(posedge clock) begin
      s1_col_ff <= s1_col_in;
      s1_y_ff   <= s1_y_in;
   end

   ctf_row_store #(
      .DEPTH (MAX_ROWS)
   ) u_row_store (
      .clock     (clock),
      .wr_en     (take),
      .wr_addr   (cnt0[AW-1:0]),
      .wr_data   (pix_row),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      s1_result.point_x = s1_col_ff;
      s1_result.point_y = s1_median_ff ? median_y : s1_y_ff;
   end

   ctf_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid_ff),
      .push_data  (s1_result),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_data  (head),
      .count      (q_count)
   );

   assign rsp_tdata = {(ctf_pkg::RSP_TDATA_W - ROW_W - COL_W)'(0), head};

endmodule
`default_nettype wire
